// ----- sv/nlsf_pkg.sv -----
// ----------------------------------------------------------------------------
// nlsf_pkg : shared types and constants for the slew filter cascade
// Sequencer states, register indexes, datapath widths and saturation helper.
// ----------------------------------------------------------------------------
package nlsf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_STAGES_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 24;

  // Serial multiplier: signed multiplicand, signed multiplier, product width
  localparam int MA_W = 34;
  localparam int MB_W = 19;
  localparam int PR_W = MA_W + 1 + MB_W;

  localparam int COEF_W  = 17;
  localparam int COUNT_W = 5;
  localparam int ONE_Q16 = 65536;
  localparam int FREQ_MIN = 7;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FREQ   = 2'd0,
    REG_NONLIN = 2'd1,
    REG_STAGES = 2'd2,
    REG_MIX    = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_P,
    ST_RD_S,
    ST_RD_END,
    ST_MUL_XN,
    ST_MUL_D,
    ST_MUL_S,
    ST_MUL_P1,
    ST_MUL_P2,
    ST_NEXT,
    ST_MIX_WET,
    ST_MIX_DRY,
    ST_DONE
  } seq_state_t;

  // Clamp a product-width value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [PR_W-1:0] v);
    logic signed [PR_W-1:0] hi;
    logic signed [PR_W-1:0] lo;
    hi = PR_W'(32'sh7FFF_FFFF);
    lo = -PR_W'(32'sh7FFF_FFFF) - PR_W'(1);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- sv/nonlinear_slew_filter_cascade_unit.sv -----
// ----------------------------------------------------------------------------
// nonlinear_slew_filter_cascade_unit : stereo nonlinear slew filter cascade
// Runs each channel through up to MAX_STAGES slew-limited one-pole stages
// and mixes the cascade output with the dry input.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  input   | in        | in_valid / in_stall   | sample_left, sample_right
//  output  | out       | out_valid / out_stall | out_left, out_right
//  config  | in/out    | APB write / read      | pwdata, prdata
//
//  All products go through one radix-2 serial multiplier, one multiplier bit
//  per cycle. A stage runs three read states, five products and one step
//  state. An item runs the stages and the wet and dry mix for the left
//  channel, then for the right; no new input is taken until it is done.
//  Synchronous reset clears the sequencer and the stage store valid bits.
//  A result waits in the output register while out_stall is high; the next
//  transfer is taken meanwhile, and waits at the end of its run.
// ----------------------------------------------------------------------------
module nonlinear_slew_filter_cascade_unit #(
  parameter int MAX_STAGES  = nlsf_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = nlsf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_left,
  input  logic signed [SAMPLE_BITS-1:0] sample_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import nlsf_pkg::*;

  localparam int FRAC   = SAMPLE_BITS - 1;
  localparam int DEPTH  = 4 * MAX_STAGES;
  localparam int KW     = $clog2(MAX_STAGES + 1);
  localparam int KIW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int ADDR_W = KIW + 2;
  localparam int CNT_W  = $clog2(MB_W);
  localparam logic signed [PR_W-1:0] SMAX = (PR_W'(1) <<< FRAC) - PR_W'(1);
  localparam logic signed [PR_W-1:0] SMIN = -(PR_W'(1) <<< FRAC);

  // Configuration registers
  logic [COEF_W-1:0]  freq_coef;
  logic [COEF_W-1:0]  nonlin_coef;
  logic [COUNT_W-1:0] stage_count;
  logic [COEF_W-1:0]  mix_control;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coef   <= COEF_W'(32768);
      nonlin_coef <= '0;
      stage_count <= COUNT_W'(2);
      mix_control <= COEF_W'(32768);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_FREQ:   freq_coef   <= pwdata[COEF_W-1:0];
        REG_NONLIN: nonlin_coef <= pwdata[COEF_W-1:0];
        REG_STAGES: stage_count <= pwdata[COUNT_W-1:0];
        REG_MIX:    mix_control <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_FREQ:   prdata = 32'(freq_coef);
      REG_NONLIN: prdata = 32'(nonlin_coef);
      REG_STAGES: prdata = 32'(stage_count);
      REG_MIX:    prdata = 32'(mix_control);
      default:    prdata = '0;
    endcase
  end

  // Effective coefficients
  logic [COEF_W-1:0]      freq_eff;
  logic [KW-1:0]          stages_eff;
  logic signed [MB_W-1:0] wet;
  logic signed [MB_W-1:0] dry_raw;
  logic signed [MB_W-1:0] dry;

  assign freq_eff   = (freq_coef < COEF_W'(FREQ_MIN)) ? COEF_W'(FREQ_MIN) : freq_coef;
  assign stages_eff = (32'(stage_count) > MAX_STAGES) ? KW'(MAX_STAGES) : KW'(stage_count);
  assign wet        = $signed({1'b0, mix_control, 1'b0}) - MB_W'(ONE_Q16);
  assign dry_raw    = MB_W'(2 * ONE_Q16) - $signed({1'b0, mix_control, 1'b0});
  assign dry        = (dry_raw > MB_W'(ONE_Q16)) ? MB_W'(ONE_Q16) : dry_raw;

  // Sequencer and datapath registers
  seq_state_t state, state_next;
  logic                     ch;
  logic [KW-1:0]            k;
  logic signed [31:0]       x;
  logic signed [31:0]       p_r;
  logic signed [31:0]       s_r;
  logic signed [SAMPLE_BITS-1:0] x0_l;
  logic signed [SAMPLE_BITS-1:0] x0_r;
  logic signed [MA_W-1:0]   amag;
  logic [COEF_W-1:0]        d;
  logic signed [PR_W-1:0]   acc;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // Serial multiplier
  logic signed [MA_W-1:0] m_a, ma_r;
  logic signed [MB_W-1:0] m_b;
  logic signed [MA_W:0]   mhi;
  logic [MB_W-1:0]        mlo;
  logic [CNT_W-1:0]       mcnt;
  logic                   mrun;
  logic                   mdone;
  logic signed [MA_W:0]   m_add;
  logic signed [MA_W:0]   m_sum;
  logic signed [PR_W-1:0] prod;
  logic                   mul_state;

  assign mul_state = (state == ST_MUL_XN) || (state == ST_MUL_D) || (state == ST_MUL_S) ||
                     (state == ST_MUL_P1) || (state == ST_MUL_P2) ||
                     (state == ST_MIX_WET) || (state == ST_MIX_DRY);
  assign m_add = mlo[0] ? (MA_W + 1)'(ma_r) : '0;
  assign m_sum = (mcnt == CNT_W'(MB_W - 1)) ? (mhi - m_add) : (mhi + m_add);
  assign prod  = $signed({mhi, mlo});

  // Select operands for the product of the current state
  always_comb begin
    m_a = MA_W'(x);
    m_b = '0;
    unique case (state)
      ST_MUL_XN: m_b = MB_W'(nonlin_coef);
      ST_MUL_D: begin
        m_a = amag;
        m_b = MB_W'(freq_eff);
      end
      ST_MUL_S: begin
        m_a = MA_W'(x) - MA_W'(p_r) + MA_W'(s_r);
        m_b = MB_W'(d);
      end
      ST_MUL_P1: m_b = MB_W'(d);
      ST_MUL_P2: begin
        m_a = MA_W'(p_r) + MA_W'(s_r);
        m_b = MB_W'(COEF_W'(ONE_Q16) - d);
      end
      ST_MIX_WET: m_b = wet;
      ST_MIX_DRY: begin
        m_a = ch ? MA_W'(x0_r) : MA_W'(x0_l);
        m_b = dry;
      end
      default: ;
    endcase
  end

  // Results taken from a finished product
  logic signed [PR_W-1:0] xn_a;
  logic signed [PR_W-1:0] d_q;
  logic signed [PR_W-1:0] acc_sum;
  logic signed [PR_W-1:0] mix_q;
  logic signed [31:0]     s_new;
  logic signed [31:0]     p_new;
  logic signed [SAMPLE_BITS-1:0] mix_out;

  assign xn_a    = (prod >>> FRAC) + PR_W'(ONE_Q16);
  assign d_q     = prod >>> 16;
  assign acc_sum = acc + prod;
  assign s_new   = sat32(prod >>> 17);
  assign p_new   = sat32(acc_sum >>> 16);
  assign mix_q   = acc_sum >>> 16;
  assign mix_out = (mix_q > SMAX) ? SAMPLE_BITS'(SMAX) :
                   (mix_q < SMIN) ? SAMPLE_BITS'(SMIN) : mix_q[SAMPLE_BITS-1:0];

  // Stage store with a valid bit per entry; invalid entries read as zero
  logic [31:0]       mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [31:0]       rdata;
  logic              rvld;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic              wen;
  logic signed [31:0] rword;

  assign raddr = {k[KIW-1:0], ch, (state == ST_RD_S)};
  assign rword = rvld ? $signed(rdata) : 32'sd0;

  always_comb begin
    wen   = 1'b0;
    waddr = {k[KIW-1:0], ch, 1'b0};
    wdata = 32'(p_new);
    if (mdone && (state == ST_MUL_S)) begin
      wen   = 1'b1;
      waddr = {k[KIW-1:0], ch, 1'b1};
      wdata = 32'(s_new);
    end else if (mdone && (state == ST_MUL_P2)) begin
      wen   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    rvld  <= vld[raddr];
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wen) begin
      vld[waddr] <= 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = (stages_eff == '0) ? ST_MIX_WET : ST_RD_P;
      ST_RD_P:   state_next = ST_RD_S;
      ST_RD_S:   state_next = ST_RD_END;
      ST_RD_END: state_next = ST_MUL_XN;
      ST_MUL_XN: if (mdone) state_next = ST_MUL_D;
      ST_MUL_D:  if (mdone) state_next = ST_MUL_S;
      ST_MUL_S:  if (mdone) state_next = ST_MUL_P1;
      ST_MUL_P1: if (mdone) state_next = ST_MUL_P2;
      ST_MUL_P2: if (mdone) state_next = ST_NEXT;
      ST_NEXT:   state_next = (k == stages_eff) ? ST_MIX_WET : ST_RD_P;
      ST_MIX_WET: if (mdone) state_next = ST_MIX_DRY;
      ST_MIX_DRY: begin
        if (mdone) begin
          if (ch) begin
            state_next = ST_DONE;
          end else begin
            state_next = (stages_eff == '0) ? ST_MIX_WET : ST_RD_P;
          end
        end
      end
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Multiplier: load, one bit per cycle, then hold for unload
  always_ff @(posedge clk) begin
    if (rst) begin
      mrun  <= 1'b0;
      mdone <= 1'b0;
      mcnt  <= '0;
    end else if (mul_state) begin
      if (mdone) begin
        mdone <= 1'b0;
      end else if (mrun) begin
        mhi  <= m_sum >>> 1;
        mlo  <= {m_sum[0], mlo[MB_W-1:1]};
        mcnt <= mcnt + CNT_W'(1);
        if (mcnt == CNT_W'(MB_W - 1)) begin
          mrun  <= 1'b0;
          mdone <= 1'b1;
        end
      end else begin
        ma_r <= m_a;
        mhi  <= '0;
        mlo  <= m_b;
        mcnt <= '0;
        mrun <= 1'b1;
      end
    end
  end

  // Datapath updates
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= 1'b0;
      k  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x0_l <= sample_left;
            x0_r <= sample_right;
            x    <= 32'(sample_left);
            ch   <= 1'b0;
            k    <= '0;
          end
        end
        ST_RD_S:   p_r <= rword;
        ST_RD_END: s_r <= rword;
        ST_MUL_XN: begin
          if (mdone) begin
            amag <= (xn_a < 0) ? MA_W'(-xn_a) : MA_W'(xn_a);
          end
        end
        ST_MUL_D: begin
          if (mdone) begin
            d <= (d_q > PR_W'(ONE_Q16)) ? COEF_W'(ONE_Q16) : d_q[COEF_W-1:0];
          end
        end
        ST_MUL_P1: if (mdone) acc <= prod;
        ST_MUL_P2: begin
          if (mdone) begin
            x <= p_new;
            k <= k + KW'(1);
          end
        end
        ST_MIX_WET: if (mdone) acc <= prod;
        ST_MIX_DRY: begin
          if (mdone && !ch) begin
            res_l <= mix_out;
            ch    <= 1'b1;
            k     <= '0;
            x     <= 32'(x0_r);
          end else if (mdone) begin
            res_r <= mix_out;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_left  <= res_l;
        out_right <= res_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
